// ===== src/tmq_pkg.sv =====
`timescale 1ns / 1ps

package tmq_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned OP_W   = 2;
  localparam int unsigned TYPE_W = 8;
  localparam int unsigned MSG_W  = 8;
  localparam int unsigned ST_W   = 2;

  // Operation codes; code three is unused and answered with ok
  localparam logic [OP_W-1:0] OP_POST  = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

  // A zero byte marks a free slot
  localparam logic [MSG_W-1:0] EMPTY_SLOT = 8'h00;

endpackage

// ===== src/typed_message_queue_core.sv =====
`timescale 1ns / 1ps

// Typed message queue: NUM_TYPES queues of QUEUE_DEPTH byte slots, one queue
// per memory word. A transaction is accepted when start_i is high and busy_o
// is low; its result shows on status_o and head_message_o for exactly one
// cycle, marked by done_o, and must be taken then. A bad type or the unused
// operation code answers in the cycle after acceptance without going busy. A
// get from an empty queue is answered from the load state, without a scan.
// Post, get and clear keep busy_o high through the load, scan, pad and write
// states; in the pad state clear adds one free slot per removed or free
// slot. The result shows in the first cycle with busy_o low again. The
// scan passes one byte slot per cycle through the shared slot
// compare unit, between a read and a write back of the queue's
// memory word. The store reads as all zero after reset through per-queue
// valid bits, so no clearing pass is needed.
module typed_message_queue_core
  import tmq_pkg::*;
#(
  parameter int unsigned NUM_TYPES   = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [TYPE_W-1:0] queue_type_i,
  input  logic [MSG_W-1:0]  message_i,
  output logic              done_o,
  output logic [ST_W-1:0]   status_o,
  output logic [MSG_W-1:0]  head_message_o
);

  localparam int unsigned ROW_W = QUEUE_DEPTH * MSG_W;
  localparam int unsigned AW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int unsigned KW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_PAD,
    S_WRITE
  } state_e;

  state_e              state_q, state_d;
  logic                done_q, done_d;
  logic [ST_W-1:0]     status_q, status_d;
  logic [MSG_W-1:0]    head_q, head_d;
  logic [NUM_TYPES-1:0] valid_q;

  logic [OP_W-1:0]     op_q, op_d;
  logic [MSG_W-1:0]    msg_q, msg_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic [MSG_W-1:0]    taken_q, taken_d;
  logic [ROW_W-1:0]    in_q, in_d;
  logic [ROW_W-1:0]    out_q, out_d;
  logic [KW-1:0]       k_q, k_d;
  logic [NW-1:0]       n_q, n_d;
  logic                found_q, found_d;
  logic                stop_q, stop_d;

  logic [ROW_W-1:0]    mem_q [NUM_TYPES];
  logic [ROW_W-1:0]    rdata_q;
  logic                rvalid_q;
  logic                mem_re, mem_we;

  logic [ROW_W-1:0]    row_w;
  logic [MSG_W-1:0]    cur_w, nxt_w, byte_w;
  logic                emit_w, bad_type_w, last_w;

  assign bad_type_w = (queue_type_i >= TYPE_W'(NUM_TYPES));
  assign row_w      = rvalid_q ? rdata_q : '0;
  assign cur_w      = in_q[MSG_W-1:0];
  assign nxt_w      = in_q[2*MSG_W-1:MSG_W];
  assign last_w     = (k_q == KW'(QUEUE_DEPTH - 1));

  // Shared slot unit: decides the byte one scan step emits
  always_comb begin
    emit_w  = 1'b0;
    byte_w  = cur_w;
    found_d = found_q;
    stop_d  = stop_q;
    case (op_q)
      OP_POST: begin
        emit_w = 1'b1;
        if (!found_q && cur_w == EMPTY_SLOT) begin
          byte_w  = msg_q;
          found_d = 1'b1;
        end
      end
      OP_GET: begin
        emit_w = 1'b1;
        if (stop_q) begin
          byte_w = cur_w;
        end else if (last_w) begin
          byte_w = EMPTY_SLOT;
        end else if (k_q != '0 && cur_w == EMPTY_SLOT) begin
          byte_w = cur_w;
          stop_d = 1'b1;
        end else begin
          byte_w = nxt_w;
        end
      end
      OP_CLEAR: begin
        emit_w = (cur_w != EMPTY_SLOT) && (cur_w != msg_q);
      end
      default: begin
        emit_w = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    status_d = status_q;
    head_d   = head_q;
    op_d     = op_q;
    msg_d    = msg_q;
    addr_d   = addr_q;
    taken_d  = taken_q;
    in_d     = in_q;
    out_d    = out_q;
    k_d      = k_q;
    n_d      = n_q;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (bad_type_w) begin
            done_d   = 1'b1;
            status_d = ST_BAD_TYPE;
            head_d   = EMPTY_SLOT;
          end else if (operation_i != OP_POST && operation_i != OP_GET &&
                       operation_i != OP_CLEAR) begin
            done_d   = 1'b1;
            status_d = ST_OK;
            head_d   = EMPTY_SLOT;
          end else begin
            mem_re  = 1'b1;
            op_d    = operation_i;
            msg_d   = message_i;
            addr_d  = queue_type_i[AW-1:0];
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (op_q == OP_GET && row_w[MSG_W-1:0] == EMPTY_SLOT) begin
          done_d   = 1'b1;
          status_d = ST_EMPTY;
          head_d   = EMPTY_SLOT;
          state_d  = S_IDLE;
        end else begin
          in_d    = row_w;
          taken_d = row_w[MSG_W-1:0];
          k_d     = '0;
          n_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        in_d = {EMPTY_SLOT, in_q[ROW_W-1:MSG_W]};
        if (emit_w) begin
          out_d = {byte_w, out_q[ROW_W-1:MSG_W]};
          n_d   = n_q + NW'(1);
        end
        if (last_w) begin
          state_d = S_PAD;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_PAD: begin
        // fill the tail with free slots until the row is complete
        if (n_q == NW'(QUEUE_DEPTH)) begin
          state_d = S_WRITE;
        end else begin
          out_d = {EMPTY_SLOT, out_q[ROW_W-1:MSG_W]};
          n_d   = n_q + NW'(1);
        end
      end
      S_WRITE: begin
        mem_we   = 1'b1;
        done_d   = 1'b1;
        status_d = (op_q == OP_POST && !found_q) ? ST_FULL : ST_OK;
        head_d   = (op_q == OP_GET) ? taken_q : EMPTY_SLOT;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      head_q   <= EMPTY_SLOT;
      valid_q  <= '0;
      found_q  <= 1'b0;
      stop_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      status_q <= status_d;
      head_q   <= head_d;
      if (mem_we) begin
        valid_q[addr_q] <= 1'b1;
      end
      if (state_q == S_LOAD) begin
        found_q <= 1'b0;
        stop_q  <= 1'b0;
      end else if (state_q == S_SCAN) begin
        found_q <= found_d;
        stop_q  <= stop_d;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    msg_q   <= msg_d;
    addr_q  <= addr_d;
    taken_q <= taken_d;
    in_q    <= in_d;
    out_q   <= out_d;
    k_q     <= k_d;
    n_q     <= n_d;
  end

  // Row memory: one queue per word, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= out_q;
    end
    if (mem_re) begin
      rdata_q  <= mem_q[queue_type_i[AW-1:0]];
      rvalid_q <= valid_q[queue_type_i[AW-1:0]];
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign head_message_o = head_q;

endmodule

// ===== src/tmq_checker.sv =====
`timescale 1ns / 1ps

module tmq_checker
  import tmq_pkg::*;
#(
  parameter int unsigned NUM_TYPES = 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic [OP_W-1:0]   operation_i,
  input logic [TYPE_W-1:0] queue_type_i,
  input logic [MSG_W-1:0]  message_i,
  input logic              done_o,
  input logic [ST_W-1:0]   status_o,
  input logic [MSG_W-1:0]  head_message_o
);

  logic accept_w;
  logic bad_w;
  logic unused_w;

  assign accept_w = start_i && !busy_o;
  assign bad_w    = (queue_type_i >= TYPE_W'(NUM_TYPES));
  assign unused_w = (message_i == message_i);

  // Bad type answers on the next cycle without going busy
  a_bad_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w && bad_w |=> done_o && status_o == ST_BAD_TYPE && !busy_o)
    else $error("bad type transaction not answered at once");

  // Real work on a valid queue makes the block busy
  a_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w && !bad_w && unused_w &&
    (operation_i == OP_POST || operation_i == OP_GET || operation_i == OP_CLEAR)
    |=> busy_o)
    else $error("accepted queue operation did not start");

  // A taken message comes only with an ok status
  a_head_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && head_message_o != EMPTY_SLOT |-> status_o == ST_OK)
    else $error("message returned with a failing status");

  // No result without a transaction behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o) || $past(start_i))
    else $error("result strobe without a transaction");

endmodule

bind typed_message_queue_core tmq_checker #(.NUM_TYPES(NUM_TYPES)) u_tmq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .operation_i    (operation_i),
  .queue_type_i   (queue_type_i),
  .message_i      (message_i),
  .done_o         (done_o),
  .status_o       (status_o),
  .head_message_o (head_message_o)
);

// ===== verif/tb_typed_message_queue_core.sv =====
`timescale 1ns / 1ps

module tb_typed_message_queue_core;
  import tmq_pkg::*;

  localparam int unsigned NUM_TYPES    = 8;
  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // longest clear plus the result cycle, with margin
  localparam int unsigned DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
  localparam int unsigned MAX_GAP      = 2 * QUEUE_DEPTH + 6;
  localparam int unsigned NUM_ROWS     = 21;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [MSG_W-1:0] head;
  } answer_t;

  // one directed stimulus row; reps repeats the same transaction
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TYPE_W-1:0] qtype;
    logic [MSG_W-1:0]  msg;
    logic [7:0]        reps;
    logic              typed;
    answer_t           ans;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              start_i        = 1'b0;
  logic [OP_W-1:0]   operation_i    = OP_POST;
  logic [TYPE_W-1:0] queue_type_i   = '0;
  logic [MSG_W-1:0]  message_i      = EMPTY_SLOT;
  logic              busy_o;
  logic              done_o;
  logic [ST_W-1:0]   status_o;
  logic [MSG_W-1:0]  head_message_o;

  // predictor copy of the queue store
  logic [MSG_W-1:0] slot_mem [NUM_TYPES][QUEUE_DEPTH];
  answer_t          pending_answers [$];
  answer_t          want_ans;
  int unsigned      mismatch_count = 0;

  typed_message_queue_core #(
    .NUM_TYPES  (NUM_TYPES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .queue_type_i  (queue_type_i),
    .message_i     (message_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .head_message_o(head_message_o)
  );

  // directed table: typed answers only where they are obvious
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{OP_GET,    8'd0,   8'h00, 8'd1,  1'b1, '{ST_EMPTY,    8'h00}},
    '{OP_POST,   8'd0,   8'hFF, 8'd1,  1'b1, '{ST_OK,       8'h00}},
    '{OP_POST,   8'd0,   8'h01, 8'd1,  1'b0, '{ST_OK,       8'h00}},
    '{OP_POST,   8'd0,   8'h00, 8'd1,  1'b1, '{ST_OK,       8'h00}},
    '{OP_GET,    8'd0,   8'h00, 8'd1,  1'b1, '{ST_OK,       8'hFF}},
    '{OP_POST,   8'd8,   8'h55, 8'd1,  1'b1, '{ST_BAD_TYPE, 8'h00}},
    '{OP_GET,    8'd255, 8'h00, 8'd1,  1'b1, '{ST_BAD_TYPE, 8'h00}},
    '{OP_CLEAR,  8'd255, 8'h01, 8'd1,  1'b1, '{ST_BAD_TYPE, 8'h00}},
    '{OP_UNUSED, 8'd0,   8'hAA, 8'd1,  1'b1, '{ST_OK,       8'h00}},
    '{OP_UNUSED, 8'd255, 8'hAA, 8'd1,  1'b1, '{ST_BAD_TYPE, 8'h00}},
    '{OP_CLEAR,  8'd0,   8'h00, 8'd1,  1'b1, '{ST_OK,       8'h00}},
    '{OP_CLEAR,  8'd0,   8'h01, 8'd1,  1'b1, '{ST_OK,       8'h00}},
    '{OP_GET,    8'd0,   8'h00, 8'd1,  1'b1, '{ST_EMPTY,    8'h00}},
    '{OP_POST,   8'd7,   8'h80, 8'd16, 1'b0, '{ST_OK,       8'h00}},
    '{OP_POST,   8'd7,   8'h7F, 8'd1,  1'b1, '{ST_FULL,     8'h00}},
    '{OP_POST,   8'd7,   8'h00, 8'd1,  1'b1, '{ST_FULL,     8'h00}},
    '{OP_GET,    8'd7,   8'h00, 8'd1,  1'b1, '{ST_OK,       8'h80}},
    '{OP_POST,   8'd7,   8'hFE, 8'd1,  1'b0, '{ST_OK,       8'h00}},
    '{OP_CLEAR,  8'd7,   8'h80, 8'd1,  1'b1, '{ST_OK,       8'h00}},
    '{OP_GET,    8'd7,   8'h00, 8'd1,  1'b0, '{ST_OK,       8'h00}},
    '{OP_GET,    8'd7,   8'h00, 8'd1,  1'b1, '{ST_EMPTY,    8'h00}}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // applies one transaction to the predictor store and returns its answer
  function automatic answer_t predict_queue_op(input logic [OP_W-1:0] op,
                                               input logic [TYPE_W-1:0] qtype,
                                               input logic [MSG_W-1:0] msg);
    answer_t          ans;
    int               k;
    int               wr;
    logic [MSG_W-1:0] v;
    bit               stop;
    ans.status = ST_OK;
    ans.head   = EMPTY_SLOT;
    stop       = 1'b0;
    wr         = 0;
    if (qtype >= NUM_TYPES) begin
      // type is checked before the operation
      ans.status = ST_BAD_TYPE;
    end else if (op == OP_POST) begin
      ans.status = ST_FULL;
      for (k = 0; k < QUEUE_DEPTH && !stop; k++) begin
        if (slot_mem[qtype][k] == EMPTY_SLOT) begin
          slot_mem[qtype][k] = msg;
          ans.status = ST_OK;
          stop = 1'b1;
        end
      end
    end else if (op == OP_GET) begin
      if (slot_mem[qtype][0] == EMPTY_SLOT) begin
        ans.status = ST_EMPTY;
      end else begin
        ans.head = slot_mem[qtype][0];
        // shift the occupied run one place left
        for (k = 0; k < QUEUE_DEPTH && !stop; k++) begin
          if (k == QUEUE_DEPTH - 1) begin
            slot_mem[qtype][k] = EMPTY_SLOT;
            stop = 1'b1;
          end else if (slot_mem[qtype][k] == EMPTY_SLOT) begin
            stop = 1'b1;
          end else begin
            slot_mem[qtype][k] = slot_mem[qtype][k + 1];
          end
        end
      end
    end else if (op == OP_CLEAR) begin
      // drop matches, then pack in order
      for (k = 0; k < QUEUE_DEPTH; k++) begin
        if (slot_mem[qtype][k] == msg) slot_mem[qtype][k] = EMPTY_SLOT;
      end
      for (k = 0; k < QUEUE_DEPTH; k++) begin
        if (slot_mem[qtype][k] != EMPTY_SLOT) begin
          v = slot_mem[qtype][k];
          slot_mem[qtype][k] = EMPTY_SLOT;
          slot_mem[qtype][wr] = v;
          wr++;
        end
      end
    end
    return ans;
  endfunction

  // drives one transaction and waits for it to be taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [TYPE_W-1:0] qtype,
                           input logic [MSG_W-1:0] msg, input logic typed,
                           input answer_t typed_ans);
    answer_t ans;
    start_i      <= 1'b1;
    operation_i  <= op;
    queue_type_i <= qtype;
    message_i    <= msg;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    ans = predict_queue_op(op, qtype, msg);
    if (typed) ans = typed_ans;
    pending_answers.push_back(ans);
  endtask

  // random sender gap, long enough to land anywhere in a busy window
  task automatic sender_gap(input int unsigned idle_pct);
    int unsigned len;
    if ($urandom_range(99) < idle_pct) begin
      len = $urandom_range(1, MAX_GAP);
      start_i <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // holds off until every outstanding answer has come back
  task automatic wait_quiet();
    start_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly valid traffic on a few busy types, with a small message pool
  task automatic run_random(input int unsigned count, input int unsigned idle_pct);
    logic [OP_W-1:0]   op;
    logic [TYPE_W-1:0] qtype;
    logic [MSG_W-1:0]  msg;
    int unsigned       roll;
    bit                fill_mode;
    for (int unsigned i = 0; i < count; i++) begin
      fill_mode = ((i / 50) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 5) op = OP_UNUSED;
      else if (roll < 20) op = OP_CLEAR;
      else if (roll < (fill_mode ? 75 : 40)) op = OP_POST;
      else op = OP_GET;
      roll = $urandom_range(99);
      if (roll < 5) qtype = TYPE_W'($urandom_range(NUM_TYPES, 255));
      else if (roll < 70) qtype = TYPE_W'($urandom_range(0, 2));
      else qtype = TYPE_W'($urandom_range(0, NUM_TYPES - 1));
      roll = $urandom_range(99);
      if (roll < 70) msg = MSG_W'($urandom_range(1, 6));
      else if (roll < 92) msg = MSG_W'($urandom_range(0, 255));
      else msg = EMPTY_SLOT;
      send_item(op, qtype, msg, 1'b0, '0);
      sender_gap(idle_pct);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status %0d head %02h", status_o, head_message_o);
      end else begin
        want_ans = pending_answers.pop_front();
        if (status_o !== want_ans.status || head_message_o !== want_ans.head) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: status exp %0d got %0d, head exp %02h got %02h",
                     want_ans.status, status_o, want_ans.head, head_message_o);
        end
      end
    end
  end

  // main sequence
  initial begin
    for (int t = 0; t < NUM_TYPES; t++) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) slot_mem[t][k] = EMPTY_SLOT;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps) begin
        send_item(directed_rows[r].op, directed_rows[r].qtype, directed_rows[r].msg,
                  directed_rows[r].typed, directed_rows[r].ans);
        sender_gap(7);
      end
    end
    wait_quiet();

    run_random(217, 7);
    wait_quiet();
    run_random(217, 52);
    run_random(216, 0);

    wait_quiet();
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("tb_typed_message_queue_core passed");
    end else begin
      $display("tb_typed_message_queue_core failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_typed_message_queue_core failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tmq_pkg.sv
src/typed_message_queue_core.sv
src/tmq_checker.sv
verif/tb_typed_message_queue_core.sv
